/* src/paid_pkg.sv */
// ----------------------------------------------------------------------------
// paid_pkg: shared types and constants of the positional array block
// Holds the array size, the command and status codes and the packed
// transaction types of the command and response channels.
// ----------------------------------------------------------------------------
package paid_pkg;

  // Array geometry.
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int DATA_W = 32;

  // Command codes.
  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADPOS = 2'd3;

  // Command transaction.
  typedef struct packed {
    logic [1:0]               command;
    logic [CNT_W-1:0]         position;
    logic signed [DATA_W-1:0] element_value;
  } cmd_t;

  // Response transaction.
  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]         occupancy;
  } rsp_t;

endpackage

/* src/paid_ram.sv */
// ----------------------------------------------------------------------------
// paid_ram: entry storage of the positional array
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module paid_ram (
  input  logic                             clk,
  input  logic                             we,
  input  logic [paid_pkg::ADDR_W-1:0]      waddr,
  input  logic signed [paid_pkg::DATA_W-1:0] wdata,
  input  logic [paid_pkg::ADDR_W-1:0]      raddr,
  output logic signed [paid_pkg::DATA_W-1:0] rdata
);
  import paid_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/positional_array_insert_delete_core.sv */
// ----------------------------------------------------------------------------
// positional_array_insert_delete_core: packed ordered array with insert/delete
// Reads, inserts or deletes a signed word at a position and reports a status,
// the word read and the occupancy after each transaction.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+--------------------------------
//  cmd     | in        | cmd_valid, cmd_stall | command, position, element_value
//  rsp     | out       | rsp_valid, rsp_stall | status, read_data, occupancy
//
// A read passes through S_RD_WAIT to S_FINISH; a rejected command goes
// straight to S_FINISH. An insert or a delete moves each entry past the
// position in turn, with a read step and then a write step per entry, since
// the entry RAM registers its read data. Reset clears the occupancy, the
// sequencer state and the response valid; the entries need no clearing. A new
// command is taken while a response waits in the output register, and the
// sequencer holds in its last state until that register is free.
module positional_array_insert_delete_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  paid_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output paid_pkg::rsp_t rsp
);
  import paid_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_WAIT,
    S_INS_STEP,
    S_INS_WR,
    S_DEL_STEP,
    S_DEL_WR,
    S_FINISH
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         idx;
  logic [CNT_W-1:0]         pos;
  logic signed [DATA_W-1:0] word;
  logic [1:0]               res_status;
  logic signed [DATA_W-1:0] res_data;

  logic                     ram_we;
  logic [ADDR_W-1:0]        ram_waddr;
  logic signed [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]        ram_raddr;
  logic signed [DATA_W-1:0] ram_rdata;

  logic                     accept;
  logic                     rsp_free;

  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // RAM port control for each sequencer state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[ADDR_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = cmd.position[ADDR_W-1:0];
    unique case (state) inside
      S_INS_STEP: begin
        ram_raddr = ADDR_W'(idx - CNT_W'(1));
        if (idx == pos) begin
          ram_we    = 1'b1;
          ram_wdata = word;
        end
      end
      S_DEL_STEP: begin
        ram_raddr = ADDR_W'(idx + CNT_W'(1));
      end
      S_INS_WR, S_DEL_WR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  paid_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer, occupancy count and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // A response leaving with no new one behind it empties the register.
      if (rsp_valid && !rsp_stall && (state != S_FINISH)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pos        <= cmd.position;
            word       <= cmd.element_value;
            res_status <= ST_OK;
            res_data   <= '0;
            unique case (cmd.command)
              CMD_READ: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_FINISH;
                end else if (cmd.position >= count) begin
                  res_status <= ST_BADPOS;
                  state      <= S_FINISH;
                end else begin
                  state <= S_RD_WAIT;
                end
              end
              CMD_INSERT: begin
                if (count >= CNT_W'(DEPTH)) begin
                  res_status <= ST_FULL;
                  state      <= S_FINISH;
                end else if (cmd.position > count) begin
                  res_status <= ST_BADPOS;
                  state      <= S_FINISH;
                end else begin
                  idx   <= count;
                  state <= S_INS_STEP;
                end
              end
              CMD_DELETE: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_FINISH;
                end else if (cmd.position >= count) begin
                  res_status <= ST_BADPOS;
                  state      <= S_FINISH;
                end else begin
                  idx   <= cmd.position;
                  state <= S_DEL_STEP;
                end
              end
              default: begin
                state <= S_FINISH;
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          res_data <= ram_rdata;
          state    <= S_FINISH;
        end
        S_INS_STEP: begin
          // The new word lands once every later entry has moved up.
          if (idx == pos) begin
            count <= count + CNT_W'(1);
            state <= S_FINISH;
          end else begin
            state <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          idx   <= idx - CNT_W'(1);
          state <= S_INS_STEP;
        end
        S_DEL_STEP: begin
          // Stop when the last valid entry has moved down.
          if (idx + CNT_W'(1) >= count) begin
            count <= count - CNT_W'(1);
            state <= S_FINISH;
          end else begin
            state <= S_DEL_WR;
          end
        end
        S_DEL_WR: begin
          idx   <= idx + CNT_W'(1);
          state <= S_DEL_STEP;
        end
        S_FINISH: begin
          if (rsp_free) begin
            rsp_valid     <= 1'b1;
            rsp.status    <= res_status;
            rsp.read_data <= res_data;
            rsp.occupancy <= count;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* sim/positional_array_insert_delete_core_test.sv */
// ----------------------------------------------------------------------------
// positional_array_insert_delete_core_test: self-checking bench for the array
// Drives reads, inserts and deletes at chosen and random positions through the
// command channel. A behavioral copy of the packed array predicts every
// response, and the response channel is checked field by field against it.
// Both channels idle and stall at random, apart from one back-to-back stretch.
// ----------------------------------------------------------------------------
module positional_array_insert_delete_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import paid_pkg::*;

  // Command 3 has no name in the package; the block answers it with an OK status and leaves the array unchanged.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int MAX_POS      = 127;
  localparam int IDLE_PCT     = 13;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 70;
  localparam int CYCLE_LIMIT  = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Behavioral copy of the array and the responses still owed by the block.
  logic signed [DATA_W-1:0] shadow_words [DEPTH];
  int                       shadow_count = 0;
  rsp_t                     pending_rsp [$];

  logic quiet_mode = 1'b0;
  int   error_count = 0;
  int   cycle_count = 0;

  positional_array_insert_delete_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Clock generation.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL positional_array_insert_delete_core");
      $finish;
    end
  end

  // Random back-pressure on the response channel.
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= !quiet_mode && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Applies one command to the shadow array and returns the response it owes.
  function automatic rsp_t apply_command(input cmd_t c);
    rsp_t r;
    int   p;
    int   i;
    r = '0;
    r.status = ST_OK;
    p = int'(c.position);
    case (c.command)
      CMD_READ: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= shadow_count) begin
          r.status = ST_BADPOS;
        end else begin
          r.read_data = shadow_words[p];
        end
      end
      CMD_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else if (p > shadow_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = shadow_count; i > p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p] = c.element_value;
          shadow_count++;
        end
      end
      CMD_DELETE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (p >= shadow_count) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = p; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    r.occupancy = CNT_W'(shadow_count);
    return r;
  endfunction

  // Response checker. Inputs change only at rising edges, so the values seen
  // at the falling edge are the ones the next rising edge transfers.
  always @(negedge clk) begin : check_response
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        error_count++;
        $display("%0t: unexpected response, expected none, actual status %0d data %0d occ %0d",
                 $time, rsp.status, rsp.read_data, rsp.occupancy);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status) begin
          error_count++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, want.status, rsp.status);
        end
        if (rsp.read_data !== want.read_data) begin
          error_count++;
          $display("%0t: read_data mismatch, expected %0d, actual %0d",
                   $time, want.read_data, rsp.read_data);
        end
        if (rsp.occupancy !== want.occupancy) begin
          error_count++;
          $display("%0t: occupancy mismatch, expected %0d, actual %0d",
                   $time, want.occupancy, rsp.occupancy);
        end
      end
    end
  end

  // Sends one command transaction. Called and returns just after a rising edge.
  task automatic send_command(input logic [1:0] op, input int pos,
                              input logic [DATA_W-1:0] value);
    cmd_t c;
    logic taken;
    c.command       = op;
    c.position      = CNT_W'(pos);
    c.element_value = value;
    while (!quiet_mode && ($urandom_range(99) < IDLE_PCT)) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do begin
      @(negedge clk);
      taken = !cmd_stall;
      @(posedge clk);
    end while (!taken);
    pending_rsp.push_back(apply_command(c));
  endtask

  // Holds the command channel idle until every owed response has arrived.
  task automatic wait_for_responses();
    cmd_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // One random command. grow_pct steers inserts against deletes; most
  // positions fall in the legal range of the current occupancy.
  task automatic send_random_item(input int grow_pct);
    int          pick;
    int          pos;
    logic [1:0]  op;
    pick = $urandom_range(99);
    if (pick < 4) begin
      op = CMD_UNUSED;
    end else if (pick < 28) begin
      op = CMD_READ;
    end else if ($urandom_range(99) < grow_pct) begin
      op = CMD_INSERT;
    end else begin
      op = CMD_DELETE;
    end
    if ($urandom_range(99) < 88) begin
      if (op == CMD_INSERT) begin
        pos = $urandom_range(shadow_count, 0);
      end else begin
        pos = (shadow_count > 0) ? $urandom_range(shadow_count - 1, 0) : 0;
      end
    end else if (op == CMD_INSERT) begin
      pos = $urandom_range(MAX_POS, shadow_count + 1);
    end else begin
      pos = $urandom_range(MAX_POS, shadow_count);
    end
    send_command(op, pos, $urandom());
  endtask

  // Every command against an empty array, including out-of-range positions.
  task automatic test_empty_array();
    send_command(CMD_READ, 0, 32'h0);
    send_command(CMD_DELETE, 0, 32'h0);
    send_command(CMD_READ, MAX_POS, 32'h0);
    send_command(CMD_DELETE, MAX_POS, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 1, 32'h1234_5678);
    send_command(CMD_INSERT, MAX_POS, 32'hFFFF_FFFF);
    send_command(CMD_UNUSED, 0, 32'h0);
  endtask

  // Extreme words at the front, the back and the middle, then boundary reads
  // and deletes, and the unused command with every bit set.
  task automatic test_field_extremes();
    send_command(CMD_INSERT, 0, 32'h7FFF_FFFF);
    send_command(CMD_INSERT, 0, 32'h8000_0000);
    send_command(CMD_INSERT, 2, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 1, 32'h0000_0000);
    send_command(CMD_INSERT, 4, 32'h5555_5555);
    send_command(CMD_INSERT, 2, 32'hAAAA_AAAA);
    send_command(CMD_READ, 0, 32'h0);
    send_command(CMD_READ, shadow_count - 1, 32'h0);
    send_command(CMD_READ, shadow_count, 32'h0);
    send_command(CMD_DELETE, shadow_count, 32'h0);
    send_command(CMD_DELETE, shadow_count - 1, 32'h0);
    send_command(CMD_DELETE, 0, 32'h0);
    send_command(CMD_READ, 1, 32'h0);
    send_command(CMD_UNUSED, MAX_POS, 32'hFFFF_FFFF);
    send_command(CMD_READ, 0, 32'h0);
  endtask

  // Fill to capacity, probe the full cases, drain to empty, probe again.
  task automatic test_fill_and_drain();
    while (shadow_count < DEPTH) begin
      send_command(CMD_INSERT, $urandom_range(shadow_count, 0), $urandom());
    end
    send_command(CMD_INSERT, 0, 32'h0BAD_0BAD);
    send_command(CMD_INSERT, MAX_POS, 32'hFFFF_FFFF);
    send_command(CMD_READ, DEPTH - 1, 32'h0);
    send_command(CMD_READ, DEPTH, 32'h0);
    send_command(CMD_DELETE, DEPTH, 32'h0);
    send_command(CMD_INSERT, DEPTH, 32'h0);
    send_command(CMD_DELETE, DEPTH - 1, 32'h0);
    send_command(CMD_INSERT, DEPTH - 1, 32'hCAFE_F00D);
    wait_for_responses();
    while (shadow_count > 0) begin
      send_command(CMD_DELETE, $urandom_range(shadow_count - 1, 0), $urandom());
    end
    send_command(CMD_DELETE, MAX_POS, 32'h0);
    send_command(CMD_READ, 0, 32'h0);
  endtask

  // Random traffic in segments that grow, shrink or hover around a level.
  task automatic test_random_traffic(input int items);
    int done;
    int seg_len;
    int grow_pct;
    done = 0;
    while (done < items) begin
      seg_len = $urandom_range(120, 20);
      case ($urandom_range(2))
        0:       grow_pct = 85;
        1:       grow_pct = 15;
        default: grow_pct = 50;
      endcase
      repeat (seg_len) send_random_item(grow_pct);
      done += seg_len;
    end
  endtask

  // Random traffic with no idling on either side.
  task automatic test_back_to_back(input int items);
    quiet_mode <= 1'b1;
    @(posedge clk);
    repeat (items) send_random_item(($urandom_range(1) == 0) ? 70 : 30);
    quiet_mode <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_array();
    test_field_extremes();
    wait_for_responses();
    test_fill_and_drain();
    test_random_traffic(700);
    wait_for_responses();
    test_back_to_back(300);
    test_random_traffic(500);

    wait_for_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS positional_array_insert_delete_core");
    end else begin
      $display("FAIL positional_array_insert_delete_core");
    end
    $finish;
  end

endmodule
